// File: hw/rtl/sha512_pkg.sv
`default_nettype none
package sha512_pkg;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [6:0] LAST_ROUND = 7'd79;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha512_round.sv
`default_nettype none
// One SHA-512 round: working variable update plus schedule expansion.
module sha512_round (
    input  wire logic [63:0] i_v [8],
    input  wire logic [63:0] i_k,
    input  wire logic [63:0] i_w,
    input  wire logic [63:0] i_w2,
    input  wire logic [63:0] i_w7,
    input  wire logic [63:0] i_w15,
    input  wire logic        i_expand,
    output logic      [63:0] o_v [8],
    output logic      [63:0] o_w
);
    logic [63:0] s0, s1, w, t1, t2;

    always_comb begin
        s1 = sha512_pkg::rotr(i_w2, 19) ^ sha512_pkg::rotr(i_w2, 61) ^ (i_w2 >> 6);
        s0 = sha512_pkg::rotr(i_w15, 1) ^ sha512_pkg::rotr(i_w15, 8) ^ (i_w15 >> 7);
        w  = i_expand ? (s1 + i_w7 + s0 + i_w) : i_w;
        t1 = i_v[7] + (sha512_pkg::rotr(i_v[4], 14) ^ sha512_pkg::rotr(i_v[4], 18)
             ^ sha512_pkg::rotr(i_v[4], 41)) + ((i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]))
             + i_k + w;
        t2 = (sha512_pkg::rotr(i_v[0], 28) ^ sha512_pkg::rotr(i_v[0], 34)
             ^ sha512_pkg::rotr(i_v[0], 39))
             + ((i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]));
        o_v[0] = t1 + t2;
        o_v[1] = i_v[0];
        o_v[2] = i_v[1];
        o_v[3] = i_v[2];
        o_v[4] = i_v[3] + t1;
        o_v[5] = i_v[4];
        o_v[6] = i_v[5];
        o_v[7] = i_v[6];
        o_w    = w;
    end
endmodule
`default_nettype wire

// File: hw/rtl/sha512_hash_engine.sv
`default_nettype none
// SHA-512 engine, byte in, digest words out.
// Input channel: one request per message byte (i_byte_present), with
// i_end_of_message on the last request; a request with neither bit set is
// a no-op. Bytes are packed big-endian into a 1024-bit block.
// A byte that does not finish a block leaves o_ready high for the next
// request. The 128th byte of a block starts a compression: 80 rounds
// through the shared round unit plus a fold into the chaining values,
// during which o_ready is low. An end request pads the block, then
// compresses one or two blocks, then presents the eight digest words,
// word 0 first, one per accepted output request. An end request whose
// byte closes a block first compresses that block, then pads and
// compresses the length block.
// The round unit is the single 64-bit datapath reused for every round;
// its carry chain sets the clock.
// Reset restores the standard initial hash value and a zero bit count.
// A stalled output (i_ready low) holds the current digest word; no new
// input is taken until all eight words are delivered.
module sha512_hash_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [63:0] o_digest_word,
    output logic      [2:0]  o_word_index,
    output logic             o_last_word
);
    sha512_pkg::t_state r_state, n_state;
    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [16];
    logic [63:0] r_len;
    logic [6:0]  r_round;
    logic        r_final;   // compression belongs to end of message
    logic        r_second;  // a length-only block still follows
    logic [2:0]  r_idx;
    logic        r_pad_done; // padding of the current message already placed

    logic [63:0] rv_next [8];
    logic [63:0] rw_next;
    logic        acc;
    logic [6:0]  pos;
    logic [63:0] len_b;

    sha512_round u_round (
        .i_v      (r_v),
        .i_k      (sha512_pkg::K[r_round]),
        .i_w      (r_w[r_round[3:0]]),
        .i_w2     (r_w[r_round[3:0] - 4'd2]),
        .i_w7     (r_w[r_round[3:0] - 4'd7]),
        .i_w15    (r_w[r_round[3:0] - 4'd15]),
        .i_expand (r_round >= 7'd16),
        .o_v      (rv_next),
        .o_w      (rw_next)
    );

    assign acc   = i_valid && o_ready;
    assign pos   = r_len[9:3];
    assign len_b = i_byte_present ? r_len + 64'd8 : r_len;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sha512_pkg::ST_COLLECT:
                if (acc) begin
                    if (i_byte_present && pos == 7'd127) n_state = sha512_pkg::ST_ROUND;
                    else if (i_end_of_message) n_state = sha512_pkg::ST_PAD;
                end
            sha512_pkg::ST_PAD:   n_state = sha512_pkg::ST_ROUND;
            sha512_pkg::ST_ROUND:
                if (r_round == sha512_pkg::LAST_ROUND) n_state = sha512_pkg::ST_FOLD;
            sha512_pkg::ST_FOLD:
                if (r_second) n_state = sha512_pkg::ST_ROUND;
                else if (r_final && !r_pad_done) n_state = sha512_pkg::ST_PAD;
                else if (r_final) n_state = sha512_pkg::ST_EMIT;
                else n_state = sha512_pkg::ST_COLLECT;
            sha512_pkg::ST_EMIT:
                if (i_ready && r_idx == 3'd7) n_state = sha512_pkg::ST_COLLECT;
            default: n_state = sha512_pkg::ST_COLLECT;
        endcase
    end

    always_comb begin
        o_ready       = (r_state == sha512_pkg::ST_COLLECT);
        o_valid       = (r_state == sha512_pkg::ST_EMIT);
        o_digest_word = r_h[r_idx];
        o_word_index  = r_idx;
        o_last_word   = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha512_pkg::ST_COLLECT;
            r_len    <= '0;
            r_round  <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_idx    <= '0;
            r_h      <= sha512_pkg::IV;
        end else begin
            r_state <= n_state;
            case (r_state)
                sha512_pkg::ST_COLLECT:
                    if (acc) begin
                        r_len <= len_b;
                        if (i_byte_present) begin
                            if (pos[2:0] == 3'd0)
                                r_w[pos[6:3]] <= {i_data_byte, 56'd0};
                            else
                                r_w[pos[6:3]][63 - 8*pos[2:0] -: 8] <= i_data_byte;
                        end
                        r_final <= i_end_of_message;
                        r_v     <= r_h;
                    end
                sha512_pkg::ST_PAD: begin
                    // place 0x80, clear tail, and add length if it fits
                    for (int i = 0; i < 16; i++) begin
                        if (i == 15 && pos < 7'd112) begin
                            r_w[i] <= r_len;
                        end else if (i == int'(pos[6:3])) begin
                            if (pos[2:0] == 3'd0) r_w[i] <= 64'h80 << 56;
                            else r_w[i] <= (r_w[i] & ~(64'hffffffffffffffff
                                >> (8*pos[2:0]))) | (64'h80 << (56 - 8*pos[2:0]));
                        end else if (i > int'(pos[6:3])) r_w[i] <= '0;
                    end
                    r_second <= (pos >= 7'd112);
                    r_v <= r_h;
                end
                sha512_pkg::ST_ROUND: begin
                    r_v <= rv_next;
                    r_w[r_round[3:0]] <= rw_next;
                    r_round <= (r_round == sha512_pkg::LAST_ROUND) ? '0 : r_round + 7'd1;
                end
                sha512_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                        r_v[i] <= r_h[i] + r_v[i];
                    end
                    if (r_second) begin
                        // length-only block
                        for (int i = 0; i < 15; i++) r_w[i] <= '0;
                        r_w[15]  <= r_len;
                        r_second <= 1'b0;
                    end
                end
                sha512_pkg::ST_EMIT:
                    if (i_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_h   <= sha512_pkg::IV;
                            r_len <= '0;
                        end
                    end
                default: ;
            endcase
        end
    end

    // pad still owed when a block-closing byte also ended the message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pad_done <= 1'b0;
        else if (r_state == sha512_pkg::ST_PAD) r_pad_done <= 1'b1;
        else if (r_state == sha512_pkg::ST_COLLECT) r_pad_done <= 1'b0;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken during digest output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_digest_word) && $stable(o_word_index))
        else $error("digest word changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha512_pkg::ST_ROUND && r_round == sha512_pkg::LAST_ROUND)
        |=> r_state == sha512_pkg::ST_FOLD) else $error("round count overrun");
endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // Request as queued for the driver; a pause entry holds the sender
    // until every outstanding digest word has been delivered.
    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
        bit         pause;
    } t_msg_req;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha512_hash_engine u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    localparam logic [63:0] HASH_INIT [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    // Predictor state: chaining values, block words and running bit count.
    logic [63:0] hash_cv [8];
    logic [63:0] block_w [16];
    logic [63:0] msg_bits;

    t_msg_req    req_q [$];
    t_digest_exp digest_q [$];

    bit  in_fire;
    int  send_gap;
    int  recv_wait;
    int  cycles;
    int  errors;
    int  words_seen;
    int  msgs_sent;
    int  bytes_sent;
    bit  stim_done;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Run the 80-round compression over block_w into hash_cv.
    task automatic compress_block();
        logic [63:0] v [8];
        logic [63:0] a2, a15, t1, t2, w;
        for (int i = 0; i < 8; i++) v[i] = hash_cv[i];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                a2  = block_w[(t - 2) & 15];
                a15 = block_w[(t - 15) & 15];
                block_w[t & 15] = (ror64(a2, 19) ^ ror64(a2, 61) ^ (a2 >> 6))
                    + block_w[(t - 7) & 15]
                    + (ror64(a15, 1) ^ ror64(a15, 8) ^ (a15 >> 7))
                    + block_w[t & 15];
            end
            w  = block_w[t & 15];
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_cv[i] += v[i];
    endtask

    task automatic place_byte(input int pos, input logic [7:0] b);
        if ((pos & 7) == 0) block_w[(pos >> 3) & 15] = '0;
        block_w[(pos >> 3) & 15][56 - 8 * (pos & 7) +: 8] = b;
    endtask

    // Absorb one accepted request; on end of message pad, finish the hash
    // and queue the eight digest words.
    task automatic absorb_request(input logic [7:0] b, input logic present,
                                  input logic eom);
        int          pos;
        t_digest_exp e;
        if (present) begin
            pos = int'(msg_bits[9:3]);
            place_byte(pos, b);
            msg_bits += 64'd8;
            if (pos == 127) compress_block();
        end
        if (eom) begin
            pos = int'(msg_bits[9:3]);
            place_byte(pos, 8'h80);
            for (int i = (pos >> 3) + 1; i < 16; i++) block_w[i] = '0;
            // Tail overflow: length does not fit, spill into a second block.
            if (pos >= 112) begin
                compress_block();
                for (int i = 0; i < 14; i++) block_w[i] = '0;
            end
            block_w[14] = '0;
            block_w[15] = msg_bits;
            compress_block();
            for (int i = 0; i < 8; i++) begin
                e.word = hash_cv[i];
                e.idx  = 3'(i);
                e.last = (i == 7);
                digest_q = {digest_q, e};
                hash_cv[i] = HASH_INIT[i];
            end
            msg_bits = '0;
        end
    endtask

    task automatic queue_req(input logic [7:0] b, input logic present, input logic eom);
        t_msg_req r;
        r.data = b; r.present = present; r.eom = eom; r.pause = 0;
        req_q = {req_q, r};
    endtask

    task automatic queue_pause();
        t_msg_req r;
        r.data = '0; r.present = 0; r.eom = 0; r.pause = 1;
        req_q = {req_q, r};
    endtask

    // Queue a message of random bytes, sprinkled with no-op requests; close
    // it either on the last byte or with a separate empty end marker.
    task automatic queue_message(input int len, input bit sep_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) queue_req(8'($urandom), 1'b0, 1'b0);
            queue_req(8'($urandom), 1'b1, !sep_end && (i == len - 1));
        end
        if (sep_end || len == 0) queue_req(8'($urandom), 1'b0, 1'b1);
        msgs_sent++;
        bytes_sent += len;
    endtask

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter doubles as the watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[sha512_hash_engine] ERROR");
            $finish;
        end
    end

    // Accept side: feed the predictor on every request handshake.
    always @(posedge i_clk) begin
        in_fire <= (i_valid && o_ready) === 1'b1;
        if (i_rst_n && (i_valid && o_ready) === 1'b1)
            absorb_request(i_data_byte, i_byte_present, i_end_of_message);
    end

    // Driver: advance at the falling edge, hold payload until accepted.
    always @(negedge i_clk) begin
        logic nv;
        nv = i_valid;
        if (i_rst_n && !(i_valid && !in_fire)) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (req_q.size() > 0) begin
                if (req_q[0].pause) begin
                    // Drop the pause once every digest word is out.
                    if (digest_q.size() == 0) void'(req_q.pop_front());
                end else begin
                    i_data_byte      <= req_q[0].data;
                    i_byte_present   <= req_q[0].present;
                    i_end_of_message <= req_q[0].eom;
                    void'(req_q.pop_front());
                    nv = 1'b1;
                    // Mostly back-to-back, with a random idle gap for about one request in three.
                    send_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
                end
            end
        end
        i_valid <= nv;
    end

    // Receiver: stall counted down here, drawn per delivered word below.
    always @(negedge i_clk) begin
        if (recv_wait > 0) begin
            recv_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: compare each delivered word with the oldest expectation.
    always @(posedge i_clk) begin
        t_digest_exp e;
        if (i_rst_n && (o_valid && i_ready) === 1'b1) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time,
                         o_digest_word, o_word_index);
                errors++;
            end else begin
                e = digest_q.pop_front();
                if (o_digest_word !== e.word) begin
                    $display("%0t: digest word exp %h got %h", $time, e.word, o_digest_word);
                    errors++;
                end
                if (o_word_index !== e.idx) begin
                    $display("%0t: word index exp %0d got %0d", $time, e.idx, o_word_index);
                    errors++;
                end
                if (o_last_word !== e.last) begin
                    $display("%0t: last word exp %0d got %0d", $time, e.last, o_last_word);
                    errors++;
                end
            end
            // One long hold-off mid-run so the engine backs up the sender.
            if (words_seen == 12)
                recv_wait = LONG_HOLD;
            else
                recv_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
        end
    end

    initial begin
        int items;
        i_rst_n = 0;
        i_valid = 0;
        i_data_byte = '0;
        i_byte_present = 0;
        i_end_of_message = 0;
        i_ready = 0;
        in_fire = 0;
        send_gap = 0;
        recv_wait = 0;
        cycles = 0;
        errors = 0;
        words_seen = 0;
        msgs_sent = 0;
        bytes_sent = 0;
        for (int i = 0; i < 8; i++) hash_cv[i] = HASH_INIT[i];
        for (int i = 0; i < 16; i++) block_w[i] = '0;
        msg_bits = '0;

        // Directed: empty message, no-op request, byte extremes, "abc".
        queue_req(8'h00, 1'b0, 1'b1);
        queue_req(8'h5a, 1'b0, 1'b0);
        queue_req(8'h00, 1'b1, 1'b1);
        queue_req(8'hff, 1'b1, 1'b1);
        queue_req(8'h80, 1'b1, 1'b0);
        queue_req(8'h7f, 1'b1, 1'b0);
        queue_req(8'hff, 1'b0, 1'b1);
        queue_pause();
        queue_req(8'h61, 1'b1, 1'b0);
        queue_req(8'h62, 1'b1, 1'b0);
        queue_req(8'h63, 1'b1, 1'b1);
        queue_req(8'haa, 1'b1, 1'b0);
        queue_req(8'h55, 1'b1, 1'b1);
        msgs_sent = 6;
        bytes_sent = 9;

        // Random: a full block closed by its last byte, then short ones.
        queue_message(128, 0);
        queue_pause();
        items = 0;
        while (items < 50) begin
            int len;
            len = $urandom_range(0, 16);
            queue_message(len, $urandom_range(0, 3) == 0);
            items += len + 1;
            if ($urandom_range(0, 9) == 0) queue_pause();
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        wait (req_q.size() == 0 && !i_valid && digest_q.size() == 0);
        repeat (200) @(posedge i_clk);

        $display("covered %0d messages, %0d bytes, %0d digest words checked",
                 msgs_sent, bytes_sent, words_seen);
        $display("including empty, short and block-closing messages under stalls");
        if (errors == 0 && digest_q.size() == 0) begin
            $display("[sha512_hash_engine] OK");
        end else begin
            $display("[sha512_hash_engine] ERROR");
        end
        $finish;
    end

endmodule
